/* src/dmd_pkg.sv */
// Shared types and constants of the datagram message deframer.
package dmd_pkg;

	// Datagram geometry
	localparam int MAX_DATAGRAM_BYTES = 256;
	localparam int CNT_W = $clog2(MAX_DATAGRAM_BYTES + 1);
	localparam int POS_W = 4;
	localparam int LEN_W = 18;

	// Header byte positions
	localparam logic [POS_W-1:0] POS_SEQ   = 4'd4;
	localparam logic [POS_W-1:0] POS_WORDS = 4'd8;
	localparam logic [POS_W-1:0] POS_FLAGS = 4'd10;
	localparam logic [POS_W-1:0] POS_LAST  = 4'd11;
	localparam logic [POS_W-1:0] HDR_BYTES = 4'd12;

	// Flag word bits
	localparam logic [15:0] LAST_FRAG_BIT  = 16'h0001;
	localparam logic [15:0] PEER_READY_BIT = 16'h0002;

	// Length check offset: header minus the word count itself
	localparam logic [LEN_W-1:0] LEN_OFFSET = 18'd10;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MAGIC = 2'd1,
		ST_OLD_SEQ   = 2'd2,
		ST_TRUNC     = 2'd3
	} status_t;

	// Classified input beat handed from front to back
	typedef struct packed {
		logic [7:0]       data;
		logic             dgram_end;
		logic             counted;
		logic             is_hdr;
		logic [POS_W-1:0] hdr_idx;
		logic             hdr_done;
		logic             magic_bad;
		logic [CNT_W-1:0] rx_count;
	} cmd_t;

	// One result beat
	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        ready_changed;
		logic        ready_value;
		logic        message_done;
		logic [15:0] message_words;
		status_t     status;
		logic        sequence_restarted;
		logic        length_mismatch;
	} res_t;

	// Magic byte expected at header positions 0..3 ("H316")
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0:    m = 8'h48;
			2'd1:    m = 8'h33;
			2'd2:    m = 8'h31;
			default: m = 8'h36;
		endcase
		return m;
	endfunction

endpackage

/* src/dmd_front.sv */
// Front end: byte counting, header position tracking, magic check and command queue.
module dmd_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [7:0]   rx_byte,
	input  logic         datagram_end,
	output logic         cmd_valid,
	output dmd_pkg::cmd_t cmd,
	input  logic         cmd_pop
);
	import dmd_pkg::*;

	logic [CNT_W-1:0] rx_q;
	logic [POS_W-1:0] pos_q;
	logic             magic_q;

	cmd_t             cls;
	logic [CNT_W-1:0] rx_n;
	logic [POS_W-1:0] pos_n;
	logic             magic_n;
	logic             accept;

	cmd_t             mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign accept = push && !full;

	// Classify the incoming byte against the datagram counters
	always_comb begin
		cls.data      = rx_byte;
		cls.dgram_end = datagram_end;
		cls.counted   = rx_q < CNT_W'(MAX_DATAGRAM_BYTES);
		cls.is_hdr    = pos_q < HDR_BYTES;
		cls.hdr_idx   = pos_q;
		rx_n          = rx_q;
		pos_n         = pos_q;
		magic_n       = magic_q;
		if (cls.counted) begin
			rx_n = rx_q + 1'b1;
			if (cls.is_hdr) begin
				pos_n = pos_q + 1'b1;
				if (pos_q < POS_SEQ && rx_byte != magic_byte(pos_q[1:0]))
					magic_n = 1'b1;
			end
		end
		cls.hdr_done  = pos_n == HDR_BYTES;
		cls.magic_bad = magic_n;
		cls.rx_count  = rx_n;
	end

	// Per-datagram counters, cleared on the final beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q    <= '0;
			pos_q   <= '0;
			magic_q <= 1'b0;
		end else if (accept) begin
			if (datagram_end) begin
				rx_q    <= '0;
				pos_q   <= '0;
				magic_q <= 1'b0;
			end else begin
				rx_q    <= rx_n;
				pos_q   <= pos_n;
				magic_q <= magic_n;
			end
		end
	end

	// Two-entry command queue
	always_ff @(posedge clk) begin
		if (accept)
			mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop && cmd_valid)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, accept} - {1'b0, cmd_pop && cmd_valid};
		end
	end

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = mem_q[rd_ptr_q];

endmodule

/* src/dmd_back.sv */
// Back end: header evaluation, sequence tracking, message state and result queue.
module dmd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  dmd_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          empty,
	input  logic          pop,
	output dmd_pkg::res_t res
);
	import dmd_pkg::*;

	logic [31:0] seq_q, seq_n;
	logic [31:0] exp_q, exp_n;
	logic [15:0] wcap_q, wcap_n;
	logic [15:0] fcap_q, fcap_n;
	logic [15:0] total_q, total_n;
	logic        peer_q, peer_n;
	logic        skip_q, skip_n;
	status_t     abort_q, abort_n;
	logic        restart_q, restart_n;
	logic        force_q, force_n;

	res_t        r;
	logic        emit;
	logic [15:0] add;
	logic [16:0] sum;
	logic        ready_bit;

	res_t        mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        res_full;
	logic        fire;
	logic        res_push;

	assign res_full = cnt_q == 2'd2;
	assign fire     = cmd_valid && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire && emit;

	// Execute one classified beat
	always_comb begin
		seq_n     = seq_q;
		exp_n     = exp_q;
		wcap_n    = wcap_q;
		fcap_n    = fcap_q;
		total_n   = total_q;
		peer_n    = peer_q;
		skip_n    = skip_q;
		abort_n   = abort_q;
		restart_n = restart_q;
		force_n   = force_q;
		r         = '0;
		emit      = 1'b0;
		add       = (wcap_q != 16'd0) ? wcap_q - 16'd1 : 16'd0;
		sum       = {1'b0, total_q} + {1'b0, add};
		ready_bit = 1'b0;

		if (cmd.counted) begin
			if (cmd.is_hdr) begin
				// field capture
				if (cmd.hdr_idx >= POS_SEQ && cmd.hdr_idx < POS_WORDS)
					seq_n = {seq_q[23:0], cmd.data};
				else if (cmd.hdr_idx >= POS_WORDS && cmd.hdr_idx < POS_FLAGS)
					wcap_n = {wcap_q[7:0], cmd.data};
				else if (cmd.hdr_idx >= POS_FLAGS)
					fcap_n = {fcap_q[7:0], cmd.data};

				// header complete
				if (cmd.hdr_idx == POS_LAST) begin
					if (cmd.magic_bad) begin
						abort_n = ST_BAD_MAGIC;
						skip_n  = 1'b1;
					end else if (!(seq_q == 32'd0 && exp_q != 32'd0) && seq_q < exp_q) begin
						abort_n = ST_OLD_SEQ;
						total_n = 16'd0;
						skip_n  = 1'b1;
					end else begin
						if (seq_q == 32'd0 && exp_q != 32'd0)
							restart_n = 1'b1;
						exp_n   = seq_q + 32'd1;
						total_n = sum[16] ? 16'hFFFF : sum[15:0];
						if (total_n == 16'd0) begin
							force_n = 1'b1;
							skip_n  = 1'b1;
						end else begin
							ready_bit = (fcap_n & PEER_READY_BIT) != 16'd0;
							if (ready_bit != peer_q) begin
								peer_n          = ready_bit;
								r.ready_changed = 1'b1;
								emit            = 1'b1;
							end
						end
					end
				end
			end else if (!skip_q) begin
				// payload forward
				r.payload_valid = 1'b1;
				r.payload_byte  = cmd.data;
				emit            = 1'b1;
			end
		end

		// end of datagram
		if (cmd.dgram_end) begin
			emit = 1'b1;
			if (!cmd.hdr_done) begin
				r.message_done = 1'b1;
				r.status       = ST_TRUNC;
				total_n        = 16'd0;
			end else begin
				if (abort_n != ST_OK || force_n || (fcap_n & LAST_FRAG_BIT) != 16'd0) begin
					r.message_done  = 1'b1;
					r.message_words = total_n;
					r.status        = abort_n;
					total_n         = 16'd0;
				end
				if (abort_n == ST_OK &&
				    LEN_W'(cmd.rx_count) != ({2'b00, wcap_n} << 1) + LEN_OFFSET)
					r.length_mismatch = 1'b1;
				r.sequence_restarted = restart_n;
			end
			abort_n   = ST_OK;
			restart_n = 1'b0;
			force_n   = 1'b0;
			skip_n    = 1'b0;
		end

		r.ready_value = peer_n;
	end

	// Message and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= '0;
			exp_q     <= '0;
			wcap_q    <= '0;
			fcap_q    <= '0;
			total_q   <= '0;
			peer_q    <= 1'b0;
			skip_q    <= 1'b0;
			abort_q   <= ST_OK;
			restart_q <= 1'b0;
			force_q   <= 1'b0;
		end else if (fire) begin
			seq_q     <= seq_n;
			exp_q     <= exp_n;
			wcap_q    <= wcap_n;
			fcap_q    <= fcap_n;
			total_q   <= total_n;
			peer_q    <= peer_n;
			skip_q    <= skip_n;
			abort_q   <= abort_n;
			restart_q <= restart_n;
			force_q   <= force_n;
		end
	end

	// Two-entry result queue
	always_ff @(posedge clk) begin
		if (res_push)
			mem_q[wr_ptr_q] <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (res_push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop && !empty)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, pop && !empty};
		end
	end

	assign empty = cnt_q == 2'd0;
	assign res   = mem_q[rd_ptr_q];

endmodule

/* src/datagram_message_deframer.sv */
// Top level of the datagram message deframer.
// Accepts one datagram byte per cycle, while full is low, through a push/full
// queue interface and presents results through an empty/pop queue interface.
// Each accepted beat is classified by the front end (byte count, header
// position, magic check) and stored in a two-entry command queue; the back end
// executes one beat per cycle while the result queue is not full (field
// capture, sequence check, word total, payload forward) and writes any result
// into a two-entry result queue. A byte is registered in the command queue and
// its result then in the result queue before it is visible; with pop held high
// the sustained rate is one byte per cycle. Bytes that cause no result still
// pass the back end but never reach the output.
module datagram_message_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        datagram_end,
	output logic        empty,
	input  logic        pop,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        ready_changed,
	output logic        ready_value,
	output logic        message_done,
	output logic [15:0] message_words,
	output logic [1:0]  status,
	output logic        sequence_restarted,
	output logic        length_mismatch
);
	import dmd_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	res_t res;

	dmd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.datagram_end (datagram_end),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	dmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	// Result fields
	assign payload_valid      = res.payload_valid;
	assign payload_byte       = res.payload_byte;
	assign ready_changed      = res.ready_changed;
	assign ready_value        = res.ready_value;
	assign message_done       = res.message_done;
	assign message_words      = res.message_words;
	assign status             = res.status;
	assign sequence_restarted = res.sequence_restarted;
	assign length_mismatch    = res.length_mismatch;

endmodule

/* verif/datagram_message_deframer_tb.sv */
// Self-checking testbench of the datagram message deframer.
module datagram_message_deframer_tb;
	import dmd_pkg::*;

	localparam logic [31:0] MAGIC_WORD = 32'h4833_3136; // "H316"
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} rx_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'h00;
	logic        datagram_end = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        ready_changed;
	logic        ready_value;
	logic        message_done;
	logic [15:0] message_words;
	logic [1:0]  status;
	logic        sequence_restarted;
	logic        length_mismatch;

	// stimulus and expectations
	rx_beat_t rx_beats[$];
	res_t     deframe_results[$];
	int       beats_queued = 0;
	logic [31:0] next_tx_seq = 32'd0;
	logic     rst_done = 1'b0;
	logic     no_idle = 1'b0;
	logic     backpressure_go = 1'b0;
	logic     rcv_hold = 1'b0;
	int       send_gap = 0;
	int       rcv_gap = 0;
	int       errors = 0;
	int unsigned cycle_count = 0;

	// deframer state mirror
	logic [POS_W-1:0] hdr_idx = '0;
	logic [31:0]      seq_shift = '0;
	logic [31:0]      next_seq = '0;
	logic [15:0]      words_shift = '0;
	logic [15:0]      flags_shift = '0;
	logic [15:0]      msg_words = '0;
	logic             peer_rdy = 1'b0;
	logic             drop_rest = 1'b0;
	int               dg_count = 0;
	logic             dg_magic_bad = 1'b0;
	status_t          dg_abort = ST_OK;
	logic             dg_restart = 1'b0;
	logic             dg_force_end = 1'b0;

	datagram_message_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.datagram_end(datagram_end),
		.empty(empty),
		.pop(pop),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.ready_changed(ready_changed),
		.ready_value(ready_value),
		.message_done(message_done),
		.message_words(message_words),
		.status(status),
		.sequence_restarted(sequence_restarted),
		.length_mismatch(length_mismatch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 100)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Deframer behavior for one accepted beat; queues its result if any
	function automatic void deframe_predict(input logic [7:0] b, input logic last_beat);
		res_t r;
		logic emit;
		logic [16:0] sum;
		logic [17:0] want_len;
		int i;
		r = '0;
		emit = 1'b0;
		if (dg_count < MAX_DATAGRAM_BYTES) begin
			dg_count++;
			if (hdr_idx < HDR_BYTES) begin
				i = int'(hdr_idx);
				// header fields shift in big-endian
				if (hdr_idx < POS_SEQ) begin
					if (b != MAGIC_WORD[31 - 8*i -: 8])
						dg_magic_bad = 1'b1;
				end else if (hdr_idx < POS_WORDS) begin
					seq_shift = {seq_shift[23:0], b};
				end else if (hdr_idx < POS_FLAGS) begin
					words_shift = {words_shift[7:0], b};
				end else begin
					flags_shift = {flags_shift[7:0], b};
				end
				// header complete: magic, sequence, word total, ready flag
				if (hdr_idx == POS_LAST) begin
					if (dg_magic_bad) begin
						dg_abort = ST_BAD_MAGIC;
						drop_rest = 1'b1;
					end else if (seq_shift != 0 && seq_shift < next_seq) begin
						dg_abort = ST_OLD_SEQ;
						msg_words = '0;
						drop_rest = 1'b1;
					end else begin
						dg_restart = (seq_shift == 0 && next_seq != 0);
						next_seq = seq_shift + 32'd1;
						sum = {1'b0, msg_words} +
							{1'b0, (words_shift != 16'd0) ? words_shift - 16'd1 : 16'd0};
						msg_words = sum[16] ? 16'hFFFF : sum[15:0];
						if (msg_words == 0) begin
							dg_force_end = 1'b1;
							drop_rest = 1'b1;
						end else if (((flags_shift & PEER_READY_BIT) != 0) != peer_rdy) begin
							peer_rdy = !peer_rdy;
							r.ready_changed = 1'b1;
							emit = 1'b1;
						end
					end
				end
				hdr_idx++;
			end else if (!drop_rest) begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				emit = 1'b1;
			end
		end
		// end of datagram
		if (last_beat) begin
			emit = 1'b1;
			if (hdr_idx < HDR_BYTES) begin
				r.message_done = 1'b1;
				r.status = ST_TRUNC;
				msg_words = '0;
			end else begin
				if (dg_abort != ST_OK || dg_force_end || (flags_shift & LAST_FRAG_BIT) != 0) begin
					r.message_done = 1'b1;
					r.message_words = msg_words;
					r.status = dg_abort;
					msg_words = '0;
				end
				want_len = ({2'b00, words_shift} << 1) + LEN_OFFSET;
				r.length_mismatch = (dg_abort == ST_OK) && (18'(dg_count) != want_len);
				r.sequence_restarted = dg_restart;
			end
			hdr_idx = '0;
			dg_count = 0;
			dg_magic_bad = 1'b0;
			drop_rest = 1'b0;
			dg_abort = ST_OK;
			dg_restart = 1'b0;
			dg_force_end = 1'b0;
		end
		if (emit) begin
			r.ready_value = peer_rdy;
			deframe_results.push_back(r);
		end
	endfunction

	// Header plus random payload; fewer than 12 bytes cuts the header short
	task automatic add_datagram(input logic [31:0] magic, input logic [31:0] seq,
		input logic [15:0] words, input logic [15:0] flags, input int len);
		logic [95:0] hdr;
		rx_beat_t bt;
		hdr = {magic, seq, words, flags};
		for (int i = 0; i < len; i++) begin
			bt.data = (i < 12) ? hdr[95 - 8*i -: 8] : 8'($urandom_range(0, 255));
			bt.last = (i == len - 1);
			rx_beats.push_back(bt);
		end
		beats_queued += len;
	endtask

	// Mostly in-order datagrams with random content, the rest broken or odd
	task automatic queue_random_traffic(input int n);
		int goal;
		int pick;
		int len;
		logic [31:0] magic;
		logic [31:0] seq;
		logic [15:0] words;
		logic [15:0] flags;
		goal = beats_queued + n;
		while (beats_queued < goal) begin
			pick = $urandom_range(0, 99);
			magic = MAGIC_WORD;
			seq = next_tx_seq;
			words = 16'($urandom_range(1, 12));
			flags = 16'($urandom_range(0, 16'hFFFF));
			len = 0;
			if (pick < 6)
				seq = 32'd0;
			else if (pick < 10)
				seq = next_tx_seq + $urandom_range(1, 5);
			else if (pick < 12)
				seq = $urandom;
			else if (pick < 18)
				seq = next_tx_seq - $urandom_range(1, 3);
			else if (pick < 22)
				magic = MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31));
			else if (pick < 26)
				len = $urandom_range(1, 11);
			else if (pick < 30)
				len = $urandom_range(12, 40);
			else if (pick < 33)
				words = 16'($urandom_range(0, 1));
			else if (pick < 36) begin
				words = 16'($urandom_range(0, 16'hFFFF));
				len = $urandom_range(12, 30);
			end else if (pick < 38) begin
				magic = $urandom;
				seq = $urandom;
				len = $urandom_range(1, 20);
			end else if (pick == 38) begin
				words = 16'($urandom_range(123, 200));
				len = $urandom_range(MAX_DATAGRAM_BYTES + 1, MAX_DATAGRAM_BYTES + 44);
			end
			if (len == 0)
				len = 2 * words + 10;
			add_datagram(magic, seq, words, flags, len);
			if (pick < 12 || pick >= 26)
				next_tx_seq = seq + 32'd1;
		end
	endtask

	task automatic wait_idle();
		while (rx_beats.size() != 0 || deframe_results.size() != 0)
			@(negedge clk);
	endtask

	// Driver: offers queued beats, predicts on each accepted beat
	always @(posedge clk) begin
		if (push && !full) begin
			deframe_predict(rx_byte, datagram_end);
			void'(rx_beats.pop_front());
			send_gap = idle_gap();
		end else if (!push && send_gap != 0) begin
			send_gap--;
		end
		if (rst_done && send_gap == 0 && rx_beats.size() != 0) begin
			push <= 1'b1;
			rx_byte <= rx_beats[0].data;
			datagram_end <= rx_beats[0].last;
		end else begin
			push <= 1'b0;
			rx_byte <= 8'($urandom_range(0, 255));
			datagram_end <= 1'($urandom_range(0, 1));
		end
	end

	// Monitor: compares each popped result beat with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (pop && !empty) begin
			if (deframe_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = deframe_results.pop_front();
				check_field("payload_valid", 32'(payload_valid), 32'(want.payload_valid));
				check_field("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
				check_field("ready_changed", 32'(ready_changed), 32'(want.ready_changed));
				check_field("ready_value", 32'(ready_value), 32'(want.ready_value));
				check_field("message_done", 32'(message_done), 32'(want.message_done));
				check_field("message_words", 32'(message_words), 32'(want.message_words));
				check_field("status", 32'(status), 32'(want.status));
				check_field("sequence_restarted", 32'(sequence_restarted),
					32'(want.sequence_restarted));
				check_field("length_mismatch", 32'(length_mismatch),
					32'(want.length_mismatch));
			end
			rcv_gap = idle_gap();
		end else if (!pop && rcv_gap != 0) begin
			rcv_gap--;
		end
		pop <= rst_done && rcv_gap == 0 && !rcv_hold;
	end

	// Long receiver hold-off while the sender keeps pushing
	initial begin
		wait (backpressure_go);
		repeat (25) @(posedge clk);
		rcv_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rcv_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		rst_done = 1'b1;

		// header cut after the first byte
		add_datagram(MAGIC_WORD, 32'd0, 16'd0, 16'd0, 1);
		// clean single-fragment message, ready rises
		add_datagram(MAGIC_WORD, 32'd0, 16'd3, PEER_READY_BIT | LAST_FRAG_BIT, 16);
		// one word only: total stays zero, message forced out
		add_datagram(MAGIC_WORD, 32'd1, 16'd1, 16'd0, 12);
		// sequence gap resyncs, ready falls
		add_datagram(MAGIC_WORD, 32'd5, 16'd2, LAST_FRAG_BIT, 14);
		// older sequence aborts
		add_datagram(MAGIC_WORD, 32'd3, 16'd2, LAST_FRAG_BIT, 14);
		// restart at zero with zero word count and wrong length
		add_datagram(MAGIC_WORD, 32'd0, 16'd0, LAST_FRAG_BIT, 12);
		// bad magic
		add_datagram(MAGIC_WORD ^ 32'd1, 32'd9, 16'd4, LAST_FRAG_BIT | PEER_READY_BIT, 18);
		// two fragments saturating the word total
		add_datagram(MAGIC_WORD, 32'd1, 16'hFFFF, PEER_READY_BIT, 14);
		add_datagram(MAGIC_WORD, 32'd2, 16'hFFFF, LAST_FRAG_BIT | PEER_READY_BIT, 13);
		// oversize datagram, end lands on an ignored byte
		add_datagram(MAGIC_WORD, 32'd3, 16'd200, LAST_FRAG_BIT, 270);
		// header one byte short
		add_datagram(MAGIC_WORD, 32'hFFFF_FFFF, 16'd2, 16'hFFFC | LAST_FRAG_BIT, 11);
		// expected number wraps, then zero follows without a restart
		add_datagram(MAGIC_WORD, 32'hFFFF_FFFF, 16'd2, LAST_FRAG_BIT, 14);
		add_datagram(MAGIC_WORD, 32'd0, 16'd2, 16'hFFFF, 14);
		// garbage
		add_datagram(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 5);
		wait_idle();

		next_tx_seq = 32'd1;
		beats_queued = 0;
		for (int c = 0; c < 4; c++) begin
			no_idle = (c == 0 || c == 2);
			if (c == 0)
				backpressure_go = 1'b1;
			queue_random_traffic(370);
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
